// File: rtl/core/bmpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpw_pkg: shared types and constants of the BMP stream writer
// Sizes, the per-pixel job record and the 54-byte header byte lookup.
// ----------------------------------------------------------------------------
package bmpw_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int SIZE_W      = 13;
    localparam int COUNT_W     = 12;
    localparam int FSIZE_W     = 32;
    localparam int IDX_W       = 6;

    localparam logic [IDX_W-1:0] HDR_BYTES = 6'd54;
    localparam logic [IDX_W-1:0] PIX_BYTES = 6'd3;

    // Configuration register indexes.
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // Everything the serialiser needs to emit the bytes of one pixel.
    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               header;
        logic [1:0]         pad;
        logic               image_end;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [FSIZE_W-1:0] fsize;
    } job_t;

    function automatic logic [7:0] hdr_byte(
        input logic [IDX_W-1:0]   idx,
        input logic [FSIZE_W-1:0] fsize,
        input logic [SIZE_W-1:0]  width,
        input logic [SIZE_W-1:0]  height
    );
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            6'd0:    b = 8'h42;
            6'd1:    b = 8'h4D;
            6'd2:    b = fsize[7:0];
            6'd3:    b = fsize[15:8];
            6'd4:    b = fsize[23:16];
            6'd5:    b = fsize[31:24];
            6'd10:   b = 8'd54;
            6'd14:   b = 8'd40;
            6'd18:   b = width[7:0];
            6'd19:   b = {3'b000, width[12:8]};
            6'd22:   b = height[7:0];
            6'd23:   b = {3'b000, height[12:8]};
            6'd26:   b = 8'd1;
            6'd28:   b = 8'd24;
            6'd49:   b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/bmpw_serializer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpw_serializer: byte serialiser for one pixel job
// Holds the current job, steps through its header, pixel and padding bytes
// and drives a registered byte output stage.
// ----------------------------------------------------------------------------
module bmpw_serializer
    import bmpw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       job_load,
    input  wire job_t       job_in,
    output logic            job_ready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tuser,
    output logic            m_tvalid,
    input  wire logic       m_tready
);

    job_t             job_reg;
    logic             job_valid_reg, job_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg;
    logic             m_last_reg;
    logic             m_eoi_reg;

    logic             emit;
    logic             last_byte;
    logic             job_done;
    logic [IDX_W-1:0] total;
    logic [IDX_W-1:0] body_idx;
    logic [7:0]       byte_val;

    always_comb begin
        total     = (job_reg.header ? HDR_BYTES : 6'd0) + PIX_BYTES + {4'b0000, job_reg.pad};
        body_idx  = idx_reg - (job_reg.header ? HDR_BYTES : 6'd0);
        last_byte = (idx_reg == total - 6'd1);
        emit      = job_valid_reg && (!m_valid_reg || m_tready);
        job_done  = emit && last_byte;
        job_ready = !job_valid_reg || job_done;

        if (job_reg.header && (idx_reg < HDR_BYTES)) begin
            byte_val = hdr_byte(idx_reg, job_reg.fsize, job_reg.width, job_reg.height);
        end else begin
            case (body_idx)
                6'd0:    byte_val = job_reg.blue;
                6'd1:    byte_val = job_reg.green;
                6'd2:    byte_val = job_reg.red;
                default: byte_val = 8'h00;
            endcase
        end

        if (job_load) begin
            job_valid_next = 1'b1;
            idx_next       = '0;
        end else if (job_done) begin
            job_valid_next = 1'b0;
            idx_next       = '0;
        end else begin
            job_valid_next = job_valid_reg;
            idx_next       = emit ? idx_reg + 6'd1 : idx_reg;
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_load) begin
            job_reg <= job_in;
        end
        if (emit) begin
            m_data_reg <= byte_val;
            m_last_reg <= last_byte;
            m_eoi_reg  <= last_byte && job_reg.image_end;
        end
    end

    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_eoi_reg;
    assign m_tvalid = m_valid_reg;

endmodule
`default_nettype wire

// File: rtl/core/bmp24_stream_writer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_stream_writer_core: 24-bit BMP byte stream writer
// Turns a stream of RGB pixels, in file order, into the bytes of a 24-bit
// uncompressed bitmap file, header and row padding included.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the s_ channel, one transaction per pixel, row by row.
// Bytes leave on the m_ channel, one transaction per byte: tlast marks the
// final byte caused by a pixel, tuser marks the final byte of the file.
// The first pixel of an image is preceded by the 54-byte header, each pixel
// gives blue, green and red bytes, and each row end adds zero padding up to
// a multiple of four bytes. After the last pixel the next image begins.
// A pixel's first byte passes the job register, then the output register.
// Bytes leave at one byte per cycle while m_tready stays high, set by the
// byte-wide output register. A pixel gives 3 bytes, 3 + (width mod 4) at a row
// end, 54 more as the first of an image; the next one is taken in the cycle
// in which the last byte of the current one moves to the output register.
// Reset clears the row and column counters and sets both sizes to 1.
// When the receiver stalls, the output byte holds and, once the job register
// is full, s_tready falls until bytes drain again.
// Users must write cfg_ sizes only while the block is idle; it does not enforce it.
// ----------------------------------------------------------------------------
module bmp24_stream_writer_core
    import bmpw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_addr,
    input  wire logic [SIZE_W-1:0] cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [23:0]       s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // out_byte [7:0]
    output logic                   m_tlast,
    output logic                   m_tuser    // end_of_image [0]
);

    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [COUNT_W-1:0] col_reg, col_next;
    logic [COUNT_W-1:0] row_reg, row_next;

    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [14:0]        row_bytes;
    logic [27:0]        data_bytes;
    logic               row_end;
    logic               image_end;
    logic               accept;
    job_t               job;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] max_v
    );
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = {{(SIZE_W-1){1'b0}}, 1'b1};
        end else if (v > max_v) begin
            r = max_v;
        end
        return r;
    endfunction

    always_comb begin
        w = clamp_size(width_reg, SIZE_W'(MAX_WIDTH));
        h = clamp_size(height_reg, SIZE_W'(MAX_HEIGHT));
        // Padding to a four-byte row equals width mod 4 for three bytes a pixel.
        row_bytes  = 15'(w) * 15'd3 + {13'b0, w[1:0]};
        data_bytes = 28'(row_bytes) * 28'(h);

        row_end   = ({1'b0, col_reg} + 13'd1) >= w;
        image_end = row_end && (({1'b0, row_reg} + 13'd1) >= h);

        job.red       = s_tdata[7:0];
        job.green     = s_tdata[15:8];
        job.blue      = s_tdata[23:16];
        job.header    = (col_reg == '0) && (row_reg == '0);
        job.pad       = row_end ? w[1:0] : 2'b00;
        job.image_end = image_end;
        job.width     = w;
        job.height    = h;
        job.fsize     = 32'(data_bytes) + 32'd54;

        accept = s_tvalid && s_tready;

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (row_end) begin
                col_next = '0;
                row_next = image_end ? '0 : row_reg + 12'd1;
            end else begin
                col_next = col_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_W'(1);
            height_reg <= SIZE_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                    default:          width_reg  <= width_reg;
                endcase
            end
        end
    end

    bmpw_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_load  (accept),
        .job_in    (job),
        .job_ready (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule
`default_nettype wire
